[sv/mser_pkg.sv]
// Shared types and constants of the multi-channel sonar echo ranger.
`timescale 1ns / 1ps

package mser_pkg;

    localparam int NUM_CH   = 4;
    localparam int CHAN_W   = 2;
    localparam int WIDTH_W  = 16;
    localparam int DIST_W   = 16;
    localparam int TIMER_W  = 21;
    localparam int PULSE_W  = 8;
    localparam int WAIT_W   = 20;
    localparam int DIV_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int STEP_W   = $clog2(WIDTH_W);

    localparam logic [PULSE_W-1:0] PULSE_RESET = PULSE_W'(10);
    localparam logic [WAIT_W-1:0]  WAIT_RESET  = WAIT_W'(100000);
    localparam logic [DIV_W-1:0]   TPCM_RESET  = DIV_W'(58);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_PULSE = 2'd0,
        CFG_SLOT_WAIT     = 2'd1,
        CFG_TICKS_PER_CM  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic               hit;
        logic [CHAN_W-1:0]  chan;
        logic [WIDTH_W-1:0] width;
    } echo_result_t;

endpackage

[sv/mser_if.sv]
// Handshake channels of the sonar echo ranger: tick input, result output, config write.
`timescale 1ns / 1ps

interface mser_in_if;
    logic                        valid;
    logic                        ready;
    logic [mser_pkg::NUM_CH-1:0] echo_levels;

    modport source (output valid, output echo_levels, input ready);
    modport sink   (input valid, input echo_levels, output ready);
endinterface

interface mser_out_if;
    logic                         valid;
    logic                         ready;
    logic [mser_pkg::NUM_CH-1:0]  trigger_levels;
    logic                         distance_valid;
    logic [mser_pkg::CHAN_W-1:0]  distance_channel;
    logic [mser_pkg::WIDTH_W-1:0] pulse_width;
    logic [mser_pkg::DIST_W-1:0]  distance_cm;

    modport source (output valid, output trigger_levels, output distance_valid,
                    output distance_channel, output pulse_width, output distance_cm,
                    input ready);
    modport sink   (input valid, input trigger_levels, input distance_valid,
                    input distance_channel, input pulse_width, input distance_cm,
                    output ready);
endinterface

interface mser_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mser_pkg::CFG_IDX_W-1:0]  index;
    logic [mser_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/mser_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module mser_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mser_pkg::WIDTH_W-1:0] dividend,
    input  logic [mser_pkg::DIV_W-1:0]   divisor,
    output logic [mser_pkg::DIST_W-1:0]  quotient,
    output mser_pkg::div_status_t        status
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [mser_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [mser_pkg::WIDTH_W-1:0] quo_reg, quo_next;
    logic [mser_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [mser_pkg::DIV_W-1:0]   dvs_reg, dvs_next;
    logic [mser_pkg::DIV_W:0]     rem_sh;
    logic [mser_pkg::DIV_W:0]     rem_sub;
    logic                         ge;

    // A zero divisor always passes the compare, giving an all-ones quotient.
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[mser_pkg::WIDTH_W-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[mser_pkg::WIDTH_W-2:0], ge};
            rem_next  = ge ? rem_sub[mser_pkg::DIV_W-1:0] : rem_sh[mser_pkg::DIV_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == mser_pkg::STEP_W'(mser_pkg::WIDTH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[sv/mser_seq.sv]
// Trigger slot sequencer: rotates one trigger pulse and wait slot over the channels.
`timescale 1ns / 1ps

module mser_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    input  logic [mser_pkg::PULSE_W-1:0] pulse_ticks,
    input  logic [mser_pkg::WAIT_W-1:0]  wait_ticks,
    output logic [mser_pkg::NUM_CH-1:0]  trigger_levels
);

    logic [mser_pkg::CHAN_W-1:0]  chan_reg, chan_next;
    logic [mser_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [mser_pkg::TIMER_W-1:0] slot_len;
    logic [mser_pkg::TIMER_W-1:0] timer_inc;

    always_comb
    begin
        slot_len = mser_pkg::TIMER_W'(pulse_ticks) + mser_pkg::TIMER_W'(wait_ticks);
        if (slot_len == '0)
        begin
            slot_len = mser_pkg::TIMER_W'(1);
        end
        timer_inc  = timer_reg + 1'b1;
        timer_next = timer_reg;
        chan_next  = chan_reg;
        if (tick)
        begin
            if (timer_inc >= slot_len)
            begin
                timer_next = '0;
                if (chan_reg == mser_pkg::CHAN_W'(mser_pkg::NUM_CH - 1))
                begin
                    chan_next = '0;
                end
                else
                begin
                    chan_next = chan_reg + 1'b1;
                end
            end
            else
            begin
                timer_next = timer_inc;
            end
        end
    end

    always_comb
    begin
        trigger_levels = '0;
        if (timer_reg < mser_pkg::TIMER_W'(pulse_ticks))
        begin
            trigger_levels[chan_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg  <= '0;
            timer_reg <= '0;
        end
        else
        begin
            chan_reg  <= chan_next;
            timer_reg <= timer_next;
        end
    end

endmodule

[sv/mser_echo.sv]
// Echo edge scan with the shared, saturating width counter.
`timescale 1ns / 1ps

module mser_echo #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick,
    input  logic [mser_pkg::NUM_CH-1:0] levels,
    output mser_pkg::echo_result_t      result
);

    logic [mser_pkg::NUM_CH-1:0]  flags_reg, flags_next;
    logic [COUNTER_BITS-1:0]      cnt_reg, cnt_next;
    logic [mser_pkg::NUM_CH-1:0]  scan_flags;
    logic                         cleared;
    logic                         hit;
    logic                         cap_zero;
    logic [mser_pkg::CHAN_W-1:0]  chan;
    logic [mser_pkg::WIDTH_W-1:0] cnt_sat;

    // Channels in ascending order; a rise below the capturing channel zeroes the capture.
    always_comb
    begin
        scan_flags = flags_reg;
        cleared    = 1'b0;
        hit        = 1'b0;
        cap_zero   = 1'b0;
        chan       = '0;
        for (int i = 0; i < mser_pkg::NUM_CH; i++)
        begin
            if (levels[i] && !scan_flags[i])
            begin
                scan_flags[i] = 1'b1;
                cleared       = 1'b1;
            end
            else if (!levels[i] && scan_flags[i])
            begin
                scan_flags[i] = 1'b0;
                hit           = 1'b1;
                chan          = mser_pkg::CHAN_W'(i);
                cap_zero      = cleared;
            end
        end
    end

    generate
        if (COUNTER_BITS > mser_pkg::WIDTH_W)
        begin : g_sat
            assign cnt_sat = (|cnt_reg[COUNTER_BITS-1:mser_pkg::WIDTH_W]) ?
                             '1 : cnt_reg[mser_pkg::WIDTH_W-1:0];
        end
        else
        begin : g_ext
            assign cnt_sat = mser_pkg::WIDTH_W'(cnt_reg);
        end
    endgenerate

    always_comb
    begin
        result.hit   = hit;
        result.chan  = chan;
        result.width = (hit && !cap_zero) ? cnt_sat : '0;
    end

    always_comb
    begin
        flags_next = flags_reg;
        cnt_next   = cnt_reg;
        if (tick)
        begin
            flags_next = scan_flags;
            if (cleared)
            begin
                cnt_next = COUNTER_BITS'(1);
            end
            else if (cnt_reg != '1)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[sv/multi_sonar_echo_ranger_core.sv]
// Top level of the four-channel sonar echo ranger: control, config and result register.
// An accepted tick passes through the control state and the output register to its result;
// a tick that ends an echo first waits on the 16-step serial divider.
// A new tick is taken only once the previous one has moved into the output register.
// Reset: rst_n clears flags, width counter, slot sequencer and control at once;
// config registers return to pulse 10, wait 100000, ticks per cm 58.
`timescale 1ns / 1ps

module multi_sonar_echo_ranger_core #(
    parameter int COUNTER_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mser_in_if.sink    echo_in,
    mser_out_if.source result_out,
    mser_cfg_if.sink   cfg
);

    // Configuration registers
    logic [mser_pkg::PULSE_W-1:0] pulse_reg;
    logic [mser_pkg::WAIT_W-1:0]  wait_reg;
    logic [mser_pkg::DIV_W-1:0]   tpcm_reg;

    // Control
    mser_pkg::state_t             state_reg, state_next;
    logic                         accept;
    logic                         div_start;
    logic                         out_load;

    // Per-tick results held while the divider works
    logic [mser_pkg::NUM_CH-1:0]  trig_now;
    mser_pkg::echo_result_t       scan;
    logic [mser_pkg::NUM_CH-1:0]  hold_trig_reg;
    mser_pkg::echo_result_t       hold_scan_reg;

    logic [mser_pkg::DIST_W-1:0]  quotient;
    mser_pkg::div_status_t        div_stat;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic [mser_pkg::NUM_CH-1:0]  out_trig_reg;
    mser_pkg::echo_result_t       out_scan_reg;
    logic [mser_pkg::DIST_W-1:0]  out_dist_reg;

    assign accept = echo_in.valid && echo_in.ready;

    // Config port never stalls; writes are only to be made while the block is idle, which the block does not enforce.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= mser_pkg::PULSE_RESET;
            wait_reg  <= mser_pkg::WAIT_RESET;
            tpcm_reg  <= mser_pkg::TPCM_RESET;
        end
        else if (cfg.valid)
        begin
            case (mser_pkg::cfg_index_t'(cfg.index))
                mser_pkg::CFG_TRIGGER_PULSE: pulse_reg <= cfg.data[mser_pkg::PULSE_W-1:0];
                mser_pkg::CFG_SLOT_WAIT:     wait_reg  <= cfg.data[mser_pkg::WAIT_W-1:0];
                mser_pkg::CFG_TICKS_PER_CM:  tpcm_reg  <= cfg.data[mser_pkg::DIV_W-1:0];
                default:
                begin
                    // Drop writes to unused indexes.
                end
            endcase
        end
    end

    // Trigger sequencer: drive comes from the slot state held before this tick.
    mser_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (accept),
        .pulse_ticks    (pulse_reg),
        .wait_ticks     (wait_reg),
        .trigger_levels (trig_now)
    );

    // Echo edge scan and width capture.
    mser_echo #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_echo (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (accept),
        .levels (echo_in.echo_levels),
        .result (scan)
    );

    // Width to centimetres, one quotient bit a cycle.
    mser_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scan.width),
        .divisor  (tpcm_reg),
        .quotient (quotient),
        .status   (div_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mser_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = scan.hit ? mser_pkg::ST_DIV : mser_pkg::ST_DONE;
                end
            end
            mser_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = mser_pkg::ST_DONE;
                end
            end
            mser_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = mser_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mser_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs: take a tick only when idle, start the divide on an echo end,
    // and move the finished item into the output register once that slot is free.
    always_comb
    begin
        echo_in.ready = (state_reg == mser_pkg::ST_IDLE);
        div_start     = (state_reg == mser_pkg::ST_IDLE) && echo_in.valid && scan.hit;
        out_load      = (state_reg == mser_pkg::ST_DONE) &&
                        (!out_valid_reg || result_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mser_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the tick's trigger drive and scan result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_trig_reg <= trig_now;
            hold_scan_reg <= scan;
        end
    end

    // Output register: advance on load, drop valid once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_trig_reg <= hold_trig_reg;
            out_scan_reg <= hold_scan_reg;
            out_dist_reg <= hold_scan_reg.hit ? quotient : '0;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.trigger_levels   = out_trig_reg;
    assign result_out.distance_valid   = out_scan_reg.hit;
    assign result_out.distance_channel = out_scan_reg.chan;
    assign result_out.pulse_width      = out_scan_reg.width;
    assign result_out.distance_cm      = out_dist_reg;

    // The divider runs only while control waits on it.
    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == mser_pkg::ST_DIV))
        else $error("divider busy outside divide state");

    // A result with no echo end carries zero channel, width and distance.
    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.distance_valid) |->
        (result_out.distance_channel == '0 && result_out.pulse_width == '0 &&
         result_out.distance_cm == '0))
        else $error("fields set on result without echo end");

    // At most one trigger is driven at a time.
    a_one_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> $onehot0(result_out.trigger_levels))
        else $error("more than one trigger driven");

    // A tick that ends an echo always starts the divider.
    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && scan.hit) |=> div_stat.busy)
        else $error("divider not started on echo end");

endmodule

[tb/multi_sonar_echo_ranger_core_tb.sv]
// Self-checking testbench of the four-channel sonar echo ranger core.
`timescale 1ns / 1ps

module multi_sonar_echo_ranger_core_tb;

    // Watchdog limit on cycles without any handshake; reaching it means the block has locked up.
    localparam int STALL_LIMIT     = 5000;
    // Leave a comfortable margin at the end of the run.
    localparam int DRAIN_CYCLES    = 40;
    // Long receiver hold-off, so that the block fills and back-pressures its input.
    localparam int PRESSURE_CYCLES = 400;
    // A long echo held on one channel.
    localparam int LONG_TICKS      = 40;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_TICKS     = 140;
    // Index 3 maps to no register; writes to it must be ignored.
    localparam logic [mser_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One result item as the block reports it.
    typedef struct packed {
        logic [mser_pkg::NUM_CH-1:0]  trig;
        logic                         hit;
        logic [mser_pkg::CHAN_W-1:0]  chan;
        logic [mser_pkg::WIDTH_W-1:0] width;
        logic [mser_pkg::DIST_W-1:0]  cm;
    } ranging_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mser_in_if  echo_ch ();
    mser_out_if result_ch ();
    mser_cfg_if cfg_ch ();

    multi_sonar_echo_ranger_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .echo_in    (echo_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: echo flags, shared width counter, slot sequencer,
    // and our own copy of the three configuration registers.
    // ------------------------------------------------------------------
    logic [mser_pkg::NUM_CH-1:0]  echo_seen  = '0;
    logic [mser_pkg::WIDTH_W-1:0] echo_width = '0;
    logic [mser_pkg::CHAN_W-1:0]  seq_chan   = '0;
    logic [mser_pkg::TIMER_W-1:0] seq_timer  = '0;
    logic [mser_pkg::PULSE_W-1:0] pulse_len  = mser_pkg::PULSE_RESET;
    logic [mser_pkg::WAIT_W-1:0]  pause_len  = mser_pkg::WAIT_RESET;
    logic [mser_pkg::DIV_W-1:0]   ticks_cm   = mser_pkg::TPCM_RESET;

    logic [mser_pkg::NUM_CH-1:0]  pending_echoes[$];   // ticks still to be offered
    ranging_t                     expected_ranges[$];  // predicted results, oldest first

    logic in_fire       = 1'b0;
    logic out_fire      = 1'b0;
    logic idle_on       = 1'b1;
    logic pressure_req  = 1'b0;
    logic pressure_done = 1'b0;
    int   send_gap      = 0;
    int   recv_gap      = 0;
    int   hold_cnt      = 0;
    int   stall_cycles  = 0;
    int   fail_count    = 0;

    // Advance the predictor by one timer tick and return the result it causes.
    function automatic ranging_t range_tick(logic [mser_pkg::NUM_CH-1:0] levels);
        ranging_t    r;
        int unsigned slot_len;
        r = '0;
        // Trigger comes from the slot state held at the start of the tick.
        if (int'(seq_timer) < int'(pulse_len))
            r.trig = 4'b0001 << seq_chan;
        // Scan from channel 0 upward; a later fall overrides an earlier one.
        for (int i = 0; i < mser_pkg::NUM_CH; i++)
        begin
            if (levels[i] && !echo_seen[i])
            begin
                echo_seen[i] = 1'b1;
                echo_width   = '0;
            end
            else if (!levels[i] && echo_seen[i])
            begin
                echo_seen[i] = 1'b0;
                r.hit        = 1'b1;
                r.chan       = mser_pkg::CHAN_W'(i);
                r.width      = echo_width;
            end
        end
        // Zero divisor saturates the distance rather than trapping.
        if (r.hit)
            r.cm = (ticks_cm == '0) ? '1 : mser_pkg::DIST_W'(r.width / ticks_cm);
        if (echo_width != '1)
            echo_width++;
        // An empty slot still lasts one tick; a shortened slot ends at once.
        slot_len = int'(pulse_len) + int'(pause_len);
        if (slot_len == 0)
            slot_len = 1;
        if (int'(seq_timer) + 1 >= slot_len)
        begin
            seq_timer = '0;
            seq_chan  = (seq_chan == mser_pkg::CHAN_W'(mser_pkg::NUM_CH - 1)) ?
                        '0 : seq_chan + 1'b1;
        end
        else
        begin
            seq_timer++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sample at the rising edge: record handshakes, predict each accepted
    // tick, and check each accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ranging_t got;
        ranging_t want;
        in_fire  <= rst_n && echo_ch.valid && echo_ch.ready;
        out_fire <= rst_n && result_ch.valid && result_ch.ready;
        if (rst_n && echo_ch.valid && echo_ch.ready)
            expected_ranges.push_back(range_tick(echo_ch.echo_levels));
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.trig  = result_ch.trigger_levels;
            got.hit   = result_ch.distance_valid;
            got.chan  = result_ch.distance_channel;
            got.width = result_ch.pulse_width;
            got.cm    = result_ch.distance_cm;
            if (expected_ranges.size() == 0)
            begin
                fail_count++;
                $display("%0t: extra result, expected none, actual %h %b %0d %0d %0d",
                         $time, got.trig, got.hit, got.chan, got.width, got.cm);
            end
            else
            begin
                want = expected_ranges.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    $display("%0t: expected %h %b %0d %0d %0d, actual %h %b %0d %0d %0d",
                             $time, want.trig, want.hit, want.chan, want.width, want.cm,
                             got.trig, got.hit, got.chan, got.width, got.cm);
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if ((echo_ch.valid && echo_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tick driver: change inputs on the falling edge. Hold an offered item
    // until it is taken, then draw the gap before the next one.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (echo_ch.valid && in_fire)
                send_gap = idle_on ? $urandom_range(0, 10) : 0;
            if (!echo_ch.valid || in_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    echo_ch.valid <= 1'b0;
                end
                else if (pending_echoes.size() != 0)
                begin
                    echo_ch.valid       <= 1'b1;
                    echo_ch.echo_levels <= pending_echoes.pop_front();
                end
                else
                begin
                    echo_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: draw a stall per item, and once hold off for a long
    // stretch so that the block backs up into its input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (pressure_req && !pressure_done)
        begin
            hold_cnt      = PRESSURE_CYCLES;
            pressure_done = 1'b1;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_fire)
                recv_gap = idle_on ? $urandom_range(0, 10) : 0;
            if (recv_gap > 0)
            begin
                recv_gap--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Write one register and mirror it into the predictor once it is taken.
    task automatic write_reg(input logic [mser_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [mser_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            mser_pkg::CFG_TRIGGER_PULSE: pulse_len = val[mser_pkg::PULSE_W-1:0];
            mser_pkg::CFG_SLOT_WAIT:     pause_len = val[mser_pkg::WAIT_W-1:0];
            mser_pkg::CFG_TICKS_PER_CM:  ticks_cm  = val[mser_pkg::DIV_W-1:0];
            default:                     ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_ranger(input logic [mser_pkg::CFG_DATA_W-1:0] pulse,
                              input logic [mser_pkg::CFG_DATA_W-1:0] pause,
                              input logic [mser_pkg::CFG_DATA_W-1:0] cm);
        write_reg(mser_pkg::CFG_TRIGGER_PULSE, pulse);
        write_reg(mser_pkg::CFG_SLOT_WAIT, pause);
        write_reg(mser_pkg::CFG_TICKS_PER_CM, cm);
    endtask

    task automatic push_ticks(input int n, input logic [mser_pkg::NUM_CH-1:0] lv);
        repeat (n) pending_echoes.push_back(lv);
    endtask

    // Wait until every queued tick is taken and every result has come back.
    task automatic settle();
        while (pending_echoes.size() != 0 || echo_ch.valid || expected_ranges.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed corner cases, random phases, then a long echo.
    // ------------------------------------------------------------------
    initial
    begin
        int                              span;
        int                              pick;
        logic [mser_pkg::CFG_DATA_W-1:0] cm_val;
        logic [mser_pkg::NUM_CH-1:0]     lv;

        echo_ch.valid       = 1'b0;
        echo_ch.echo_levels = '0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: a short echo on channel 0.
        push_ticks(2, 4'h1);
        push_ticks(1, 4'h0);
        settle();

        // Unused index is ignored; then a short slot to watch the triggers rotate.
        write_reg(CFG_UNUSED, mser_pkg::CFG_DATA_W'($urandom));
        set_ranger(20'd3, 20'd2, 20'd1);
        push_ticks(1, 4'h0);
        push_ticks(2, 4'hF);
        push_ticks(1, 4'h0);   // all four fall together: channel 3 wins
        push_ticks(1, 4'h1);
        push_ticks(1, 4'h3);
        push_ticks(1, 4'h2);
        push_ticks(1, 4'h0);
        push_ticks(2, 4'h8);
        push_ticks(1, 4'h0);
        settle();

        // No trigger pulse and a zero divisor.
        set_ranger(20'd0, 20'd3, 20'd0);
        push_ticks(2, 4'h4);
        push_ticks(2, 4'h0);
        settle();

        // Empty slot: each slot lasts a single tick.
        set_ranger(20'd0, 20'd0, 20'd58);
        push_ticks(4, 4'h0);
        settle();

        // Every data bit set: registers keep their own width only.
        set_ranger(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        push_ticks(3, 4'h2);
        push_ticks(1, 4'h0);
        settle();

        // Shrink the slot under a running timer: the slot must end at once.
        set_ranger(20'd2, 20'd3, 20'd255);
        push_ticks(4, 4'h0);
        settle();

        // Random phases: mostly held echo levels, some pure noise.
        lv = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 7))
                0:       cm_val = '0;
                1:       cm_val = 20'd1;
                2:       cm_val = 20'd255;
                3:       cm_val = mser_pkg::CFG_DATA_W'($urandom);
                default: cm_val = mser_pkg::CFG_DATA_W'($urandom_range(1, 64));
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       set_ranger(20'd255, 20'hFFFFF, cm_val);
                1:       set_ranger(20'd0, 20'd0, cm_val);
                2:       set_ranger(mser_pkg::CFG_DATA_W'($urandom),
                                    mser_pkg::CFG_DATA_W'($urandom), cm_val);
                default: set_ranger(mser_pkg::CFG_DATA_W'($urandom_range(1, 8)),
                                    mser_pkg::CFG_DATA_W'($urandom_range(0, 16)), cm_val);
            endcase
            // Every fourth phase runs flat out on both sides.
            idle_on = (ph % 4) != 3;
            if (ph == 5)
                pressure_req = 1'b1;
            span = $urandom_range(1, 30);
            for (int k = 0; k < PHASE_TICKS; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    lv = mser_pkg::NUM_CH'($urandom);
                end
                else
                begin
                    for (int c = 0; c < mser_pkg::NUM_CH; c++)
                        if ($urandom_range(0, span) == 0)
                            lv[c] = ~lv[c];
                end
                pending_echoes.push_back(lv);
            end
            settle();
        end

        // Hold channel 2 high for a long echo; divisor 1 gives the width back as distance.
        idle_on = 1'b0;
        set_ranger(20'd2, 20'd3, 20'd1);
        push_ticks(LONG_TICKS, 4'h4);
        push_ticks(3, 4'h0);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
